>>> sv/dsrp_pkg.sv
package dsrp_pkg;

    localparam int unsigned AddrWidth = 3;
    localparam int unsigned DataWidth = 32;

    localparam logic REG_ROUTE_FORMAT      = 1'b0;
    localparam logic REG_INTERFACE_ADDRESS = 1'b1;

    localparam logic FORMAT_CLASSLESS = 1'b0;
    localparam logic FORMAT_CLASSFUL  = 1'b1;

    localparam logic [5:0] MaxPrefix = 6'd32;

    typedef struct packed {
        logic [31:0] dest_address;
        logic [31:0] netmask;
        logic [31:0] gateway_address;
        logic [31:0] local_address;
        logic        direct_route;
    } route_t;

    typedef struct packed {
        logic        accept;
        logic        clear;
        logic        route_format;
        logic [31:0] interface_address;
    } parse_ctrl_t;

endpackage

>>> sv/dsrp_if.sv
interface dsrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dsrp_route_if;
    logic        valid;
    logic        ready;
    logic [31:0] dest_address;
    logic [31:0] netmask;
    logic [31:0] gateway_address;
    logic [31:0] local_address;
    logic        direct_route;

    modport source (
        output valid, output dest_address, output netmask, output gateway_address,
        output local_address, output direct_route, input ready
    );
    modport sink (
        input valid, input dest_address, input netmask, input gateway_address,
        input local_address, input direct_route, output ready
    );
endinterface

>>> sv/dhcp_static_route_option_parser.sv
// a route is registered into the output buffer from the byte that completes it
// throughput: one byte per cycle while the skid entry is empty; the parser state register closes the only loop
// a two-deep output buffer keeps byte_in ready while one route waits
// reset: rst_n is asynchronous, active low; it clears the parser, the output buffer
// and both configuration registers (classless layout, interface address zero)
module dhcp_static_route_option_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    dsrp_byte_if.sink                           byte_in,
    dsrp_route_if.source                        route_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dsrp_pkg::AddrWidth-1:0]      paddr,
    input  logic [dsrp_pkg::DataWidth-1:0]      pwdata,
    output logic [dsrp_pkg::DataWidth-1:0]      prdata,
    output logic                                pready
);
    import dsrp_pkg::*;

    logic        format_reg;
    logic [31:0] iface_reg;
    logic        cfg_write;

    parse_ctrl_t ctrl;
    logic        res_valid;
    route_t      res;

    logic        out_valid_reg, out_valid_next;
    route_t      out_reg, out_next;
    logic        skid_valid_reg, skid_valid_next;
    route_t      skid_reg, skid_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_INTERFACE_ADDRESS) ? iface_reg
                     : {{(DataWidth-1){1'b0}}, format_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FORMAT_CLASSLESS;
            iface_reg  <= 32'd0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_ROUTE_FORMAT)
            begin
                format_reg <= pwdata[0];
            end
            else
            begin
                iface_reg <= pwdata;
            end
        end
    end

    assign byte_in.ready          = !skid_valid_reg;
    assign ctrl.accept            = byte_in.valid && !skid_valid_reg;
    assign ctrl.clear             = cfg_write && (paddr[2] == REG_ROUTE_FORMAT);
    assign ctrl.route_format      = format_reg;
    assign ctrl.interface_address = iface_reg;

    dsrp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .data_byte   (byte_in.data_byte),
        .last_byte   (byte_in.last_byte),
        .route_valid (res_valid),
        .route       (res)
    );

    // output stage with skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        priority if (out_valid_reg && route_out.ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = res_valid;
            out_next       = res;
        end
        else
        begin
            if (res_valid)
            begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign route_out.valid           = out_valid_reg;
    assign route_out.dest_address    = out_reg.dest_address;
    assign route_out.netmask         = out_reg.netmask;
    assign route_out.gateway_address = out_reg.gateway_address;
    assign route_out.local_address   = out_reg.local_address;
    assign route_out.direct_route    = out_reg.direct_route;

endmodule

>>> sv/dsrp_parser.sv
module dsrp_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dsrp_pkg::parse_ctrl_t ctrl,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output logic                 route_valid,
    output dsrp_pkg::route_t     route
);
    import dsrp_pkg::*;

    localparam logic [1:0] PHASE_PREFIX  = 2'd0;
    localparam logic [1:0] PHASE_DEST    = 2'd1;
    localparam logic [1:0] PHASE_GATEWAY = 2'd2;
    localparam logic [1:0] PHASE_HALTED  = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  prefix_reg, prefix_next;
    logic [2:0]  count_reg, count_next;
    logic [31:0] dest_reg, dest_next;
    logic [31:0] gw_reg, gw_next;

    logic [2:0]  count_inc;
    logic [6:0]  need_sum;
    logic [2:0]  need;
    logic [31:0] gw_shift;
    logic [31:0] dest_shift;
    logic [31:0] dest_or;
    logic [31:0] mask;

    assign count_inc  = count_reg + 3'd1;
    assign need_sum   = {1'b0, prefix_reg} + 7'd7;
    assign need       = need_sum[5:3];
    assign gw_shift   = {gw_reg[23:0], data_byte};
    assign dest_shift = {dest_reg[23:0], data_byte};
    assign dest_or    = dest_reg | ({data_byte, 24'd0} >> {count_reg[1:0], 3'd0});
    assign mask       = (prefix_reg == 6'd0) ? 32'd0
                      : (32'hffff_ffff << (MaxPrefix - prefix_reg));

    always_comb
    begin
        phase_next  = phase_reg;
        prefix_next = prefix_reg;
        count_next  = count_reg;
        dest_next   = dest_reg;
        gw_next     = gw_reg;
        route_valid = 1'b0;
        route       = '0;

        if (ctrl.accept)
        begin
            if (ctrl.route_format == FORMAT_CLASSFUL)
            begin
                if (!count_reg[2])
                begin
                    dest_next = dest_shift;
                end
                else
                begin
                    gw_next = gw_shift;
                end
                count_next = count_inc;
                route.dest_address    = dest_reg;
                route.netmask         = 32'd0;
                route.gateway_address = gw_shift;
                route.local_address   = ctrl.interface_address;
                route.direct_route    = 1'b0;
                route_valid = (count_reg == 3'd7) && (dest_reg != 32'd0);
            end
            else
            begin
                unique case (phase_reg)
                    PHASE_PREFIX:
                    begin
                        if (data_byte > {2'b00, MaxPrefix})
                        begin
                            phase_next = PHASE_HALTED;
                        end
                        else
                        begin
                            prefix_next = data_byte[5:0];
                            count_next  = 3'd0;
                            dest_next   = 32'd0;
                            gw_next     = 32'd0;
                            phase_next  = (data_byte == 8'd0) ? PHASE_GATEWAY : PHASE_DEST;
                        end
                    end
                    PHASE_DEST:
                    begin
                        dest_next  = dest_or;
                        count_next = count_inc;
                        if (count_inc >= need)
                        begin
                            count_next = 3'd0;
                            phase_next = PHASE_GATEWAY;
                        end
                    end
                    PHASE_GATEWAY:
                    begin
                        gw_next    = gw_shift;
                        count_next = count_inc;
                        route.dest_address = dest_reg & mask;
                        route.netmask      = mask;
                        if (gw_shift == 32'd0)
                        begin
                            route.gateway_address = ctrl.interface_address;
                            route.local_address   = 32'd0;
                            route.direct_route    = 1'b1;
                        end
                        else
                        begin
                            route.gateway_address = gw_shift;
                            route.local_address   = ctrl.interface_address;
                            route.direct_route    = 1'b0;
                        end
                        if (count_inc == 3'd4)
                        begin
                            route_valid = 1'b1;
                            phase_next  = PHASE_PREFIX;
                            count_next  = 3'd0;
                        end
                    end
                    PHASE_HALTED:
                    begin
                        phase_next = PHASE_HALTED;
                    end
                    default:
                    begin
                        phase_next = PHASE_HALTED;
                    end
                endcase
            end
        end

        if (ctrl.clear || (ctrl.accept && last_byte))
        begin
            phase_next  = PHASE_PREFIX;
            prefix_next = 6'd0;
            count_next  = 3'd0;
            dest_next   = 32'd0;
            gw_next     = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PHASE_PREFIX;
            prefix_reg <= 6'd0;
            count_reg  <= 3'd0;
            dest_reg   <= 32'd0;
            gw_reg     <= 32'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            prefix_reg <= prefix_next;
            count_reg  <= count_next;
            dest_reg   <= dest_next;
            gw_reg     <= gw_next;
        end
    end

endmodule

>>> sv/dsrp_checker.sv
module dsrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] dest_address,
    input logic [31:0] netmask,
    input logic [31:0] local_address,
    input logic        direct_route
);
    logic [31:0] host_bits;
    logic [31:0] host_inc;

    assign host_bits = ~netmask;
    assign host_inc  = host_bits + 32'd1;

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("route beat dropped while stalled");

    a_direct_no_local: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && direct_route |-> local_address == 32'd0)
        else $error("direct route with nonzero local address");

    a_direct_masked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && direct_route |-> (dest_address & host_bits) == 32'd0)
        else $error("direct route destination has host bits set");

    a_mask_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (host_bits & host_inc) == 32'd0)
        else $error("netmask is not a contiguous prefix");

endmodule

bind dhcp_static_route_option_parser dsrp_checker u_dsrp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (route_out.valid),
    .out_ready     (route_out.ready),
    .dest_address  (route_out.dest_address),
    .netmask       (route_out.netmask),
    .local_address (route_out.local_address),
    .direct_route  (route_out.direct_route)
);

>>> tb/dhcp_static_route_option_parser_test.sv
module dhcp_static_route_option_parser_test;
    import dsrp_pkg::*;

    typedef enum logic [1:0] {
        PHASE_PREFIX,
        PHASE_DEST,
        PHASE_GATEWAY,
        PHASE_HALTED
    } parse_phase_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } option_beat_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [AddrWidth-1:0] paddr;
    logic [DataWidth-1:0] pwdata;
    logic [DataWidth-1:0] prdata;
    logic pready;

    dsrp_byte_if  byte_in ();
    dsrp_route_if route_out ();

    dhcp_static_route_option_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .route_out (route_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // predictor state
    logic         m_classful;
    logic [31:0]  m_if_addr;
    parse_phase_e m_phase;
    logic [5:0]   m_prefix;
    logic [2:0]   m_count;
    logic [31:0]  m_dest;
    logic [31:0]  m_gw;

    option_beat_t pending_beats[$];
    route_t       expected_routes[$];
    logic [7:0]   option_bytes[$];
    int           beats_queued;
    logic         byte_taken;
    bit           failed;

    int           burst_left;
    int           gap_left;
    logic [15:0]  ready_pattern;
    int           pattern_life;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void clear_parser();
        m_phase  = PHASE_PREFIX;
        m_prefix = '0;
        m_count  = '0;
        m_dest   = '0;
        m_gw     = '0;
    endfunction

    function automatic logic parse_route_byte(input logic [7:0] b, input logic last,
                                              output route_t r);
        logic        emit;
        logic [2:0]  pos;
        logic [31:0] mask;
        emit = 1'b0;
        r    = '0;
        pos  = m_count;
        if (m_classful)
        begin
            if (pos < 3'd4)
                m_dest = {m_dest[23:0], b};
            else
                m_gw = {m_gw[23:0], b};
            m_count = pos + 3'd1;
            if (pos == 3'd7 && m_dest != 32'd0)
            begin
                emit              = 1'b1;
                r.dest_address    = m_dest;
                r.netmask         = 32'd0;
                r.gateway_address = m_gw;
                r.local_address   = m_if_addr;
                r.direct_route    = 1'b0;
            end
        end
        else
        begin
            case (m_phase)
                PHASE_PREFIX:
                    if (b > 8'(MaxPrefix))
                        m_phase = PHASE_HALTED;
                    else
                    begin
                        m_prefix = b[5:0];
                        m_count  = '0;
                        m_dest   = '0;
                        m_gw     = '0;
                        m_phase  = (b == 8'd0) ? PHASE_GATEWAY : PHASE_DEST;
                    end
                PHASE_DEST:
                begin
                    m_dest  = m_dest | (32'(b) << (24 - 8 * int'(m_count[1:0])));
                    m_count = m_count + 3'd1;
                    if (int'(m_count) >= (int'(m_prefix) + 7) / 8)
                    begin
                        m_count = '0;
                        m_phase = PHASE_GATEWAY;
                    end
                end
                PHASE_GATEWAY:
                begin
                    m_gw    = {m_gw[23:0], b};
                    m_count = m_count + 3'd1;
                    if (m_count >= 3'd4)
                    begin
                        mask = (m_prefix == 6'd0) ? 32'd0
                                                  : 32'hffff_ffff << (6'd32 - m_prefix);
                        emit           = 1'b1;
                        r.dest_address = m_dest & mask;
                        r.netmask      = mask;
                        if (m_gw == 32'd0)
                        begin
                            r.gateway_address = m_if_addr;
                            r.local_address   = 32'd0;
                            r.direct_route    = 1'b1;
                        end
                        else
                        begin
                            r.gateway_address = m_gw;
                            r.local_address   = m_if_addr;
                            r.direct_route    = 1'b0;
                        end
                        m_phase = PHASE_PREFIX;
                        m_count = '0;
                    end
                end
                default: ;
            endcase
        end
        if (last)
            clear_parser();
        return emit;
    endfunction

    task automatic push_beat(input logic [7:0] b, input logic last);
        pending_beats.push_back('{data: b, last: last});
        beats_queued++;
    endtask

    task automatic send_option(input bit may_truncate);
        int n;
        n = option_bytes.size();
        if (may_truncate && n > 1 && $urandom_range(0, 6) == 0)
            n = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++)
            push_beat(option_bytes[i], i == n - 1);
        option_bytes.delete();
    endtask

    task automatic build_classless_option();
        int entries;
        int plen;
        int sel;
        entries = $urandom_range(1, 4);
        for (int e = 0; e < entries; e++)
        begin
            sel = $urandom_range(0, 11);
            if (sel == 0)
                plen = 0;
            else if (sel == 1)
                plen = 32;
            else if (sel == 2)
                plen = $urandom_range(33, 255);
            else
                plen = $urandom_range(1, 31);
            option_bytes.push_back(8'(plen));
            if (plen > 32)
            begin
                repeat ($urandom_range(0, 5)) option_bytes.push_back(8'($urandom));
                break;
            end
            repeat ((plen + 7) / 8) option_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 3) == 0)
                repeat (4) option_bytes.push_back(8'd0);
            else
                repeat (4) option_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic build_classful_option();
        int pairs;
        pairs = $urandom_range(1, 4);
        repeat (pairs)
        begin
            if ($urandom_range(0, 4) == 0)
                repeat (4) option_bytes.push_back(8'd0);
            else
                repeat (4) option_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 4) == 0)
                repeat (4) option_bytes.push_back(8'd0);
            else
                repeat (4) option_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic add_options(input int n_beats, input int noise_pct);
        int stop;
        stop = beats_queued + n_beats;
        while (beats_queued < stop)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                repeat ($urandom_range(1, 12)) option_bytes.push_back(8'($urandom));
            else if (m_classful)
                build_classful_option();
            else
                build_classless_option();
            send_option(1'b1);
        end
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || byte_in.valid || expected_routes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_ROUTE_FORMAT)
        begin
            m_classful = value[0];
            clear_parser();
        end
        else
            m_if_addr = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // byte sender: bursts with random gaps
    always @(negedge clk)
    begin : driver
        option_beat_t beat;
        if (!byte_in.valid || byte_taken)
        begin
            if (gap_left != 0)
            begin
                byte_in.valid <= 1'b0;
                gap_left--;
            end
            else if (pending_beats.size() != 0)
            begin
                beat = pending_beats.pop_front();
                byte_in.data_byte <= beat.data;
                byte_in.last_byte <= beat.last;
                byte_in.valid     <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                byte_in.valid <= 1'b0;
        end
    end

    // route receiver: stalls follow a rotating pattern, renewed now and then
    always @(negedge clk)
    begin : receiver
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        route_out.ready <= ready_pattern[0];
        pattern_life--;
        if (pattern_life <= 0)
        begin
            pattern_life = $urandom_range(32, 200);
            if ($urandom_range(0, 3) == 0)
                ready_pattern = 16'hffff;
            else
                ready_pattern = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
        end
    end

    always @(posedge clk)
    begin : monitor
        route_t predicted;
        route_t want;
        byte_taken = byte_in.valid && byte_in.ready;
        if (byte_taken)
        begin
            if (parse_route_byte(byte_in.data_byte, byte_in.last_byte, predicted))
                expected_routes.push_back(predicted);
        end
        if (route_out.valid && route_out.ready)
        begin
            if (expected_routes.size() == 0)
            begin
                $error("route beat with no route expected: dest_address %h",
                       route_out.dest_address);
                failed = 1'b1;
            end
            else
            begin
                want = expected_routes.pop_front();
                if (route_out.dest_address !== want.dest_address)
                begin
                    $error("dest_address: expected %h, got %h",
                           want.dest_address, route_out.dest_address);
                    failed = 1'b1;
                end
                if (route_out.netmask !== want.netmask)
                begin
                    $error("netmask: expected %h, got %h", want.netmask, route_out.netmask);
                    failed = 1'b1;
                end
                if (route_out.gateway_address !== want.gateway_address)
                begin
                    $error("gateway_address: expected %h, got %h",
                           want.gateway_address, route_out.gateway_address);
                    failed = 1'b1;
                end
                if (route_out.local_address !== want.local_address)
                begin
                    $error("local_address: expected %h, got %h",
                           want.local_address, route_out.local_address);
                    failed = 1'b1;
                end
                if (route_out.direct_route !== want.direct_route)
                begin
                    $error("direct_route: expected %b, got %b",
                           want.direct_route, route_out.direct_route);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        failed            = 1'b0;
        beats_queued      = 0;
        byte_taken        = 1'b0;
        burst_left        = 1;
        gap_left          = 0;
        ready_pattern     = 16'hffff;
        pattern_life      = 100;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        byte_in.valid     = 1'b0;
        byte_in.data_byte = 8'd0;
        byte_in.last_byte = 1'b0;
        route_out.ready   = 1'b0;
        m_classful        = FORMAT_CLASSLESS;
        m_if_addr         = 32'd0;
        clear_parser();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero prefix with zero gateway: direct route
        push_beat(8'd0, 1'b0);
        repeat (3) push_beat(8'd0, 1'b0);
        push_beat(8'd0, 1'b1);
        // full prefix, all ones everywhere
        push_beat(8'd32, 1'b0);
        repeat (7) push_beat(8'hff, 1'b0);
        push_beat(8'hff, 1'b1);
        // prefix too long halts until the end of the option
        push_beat(8'hff, 1'b0);
        push_beat(8'h5a, 1'b1);
        // truncated entry
        push_beat(8'd9, 1'b0);
        push_beat(8'hab, 1'b1);

        settle();
        reg_write(REG_INTERFACE_ADDRESS, 32'hffff_ffff);
        add_options(300, 10);

        // leave an entry half parsed; the format write clears it
        push_beat(8'd24, 1'b0);
        push_beat(8'd10, 1'b0);
        push_beat(8'd20, 1'b0);
        settle();
        reg_write(REG_ROUTE_FORMAT, {31'd0, FORMAT_CLASSFUL});

        // interface address written mid-pair keeps the pair going
        push_beat(8'd10, 1'b0);
        push_beat(8'd20, 1'b0);
        push_beat(8'd30, 1'b0);
        settle();
        reg_write(REG_INTERFACE_ADDRESS, $urandom);
        push_beat(8'd40, 1'b0);
        push_beat(8'd1, 1'b0);
        push_beat(8'd2, 1'b0);
        push_beat(8'd3, 1'b0);
        push_beat(8'd4, 1'b0);
        // zero destination skipped, then a zero gateway kept as an ordinary route
        repeat (4) push_beat(8'd0, 1'b0);
        repeat (4) push_beat(8'($urandom), 1'b0);
        repeat (4) push_beat(8'hff, 1'b0);
        repeat (3) push_beat(8'd0, 1'b0);
        push_beat(8'd0, 1'b1);
        add_options(260, 10);

        settle();
        reg_write(REG_ROUTE_FORMAT, {31'd0, FORMAT_CLASSLESS});
        reg_write(REG_INTERFACE_ADDRESS, 32'd0);
        add_options(150, 10);
        settle();
        add_options(150, 10);

        settle();
        reg_write(REG_ROUTE_FORMAT, {31'd0, FORMAT_CLASSFUL});
        add_options(200, 10);

        settle();
        reg_write(REG_ROUTE_FORMAT, {31'd0, FORMAT_CLASSLESS});
        reg_write(REG_INTERFACE_ADDRESS, $urandom);
        add_options(250, 25);

        settle();
        if (!failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
